// ===== rtl/sebam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sebam_pkg: shared types and constants
// Item and result formats and the SPI opcodes of the EEPROM access master.
// ----------------------------------------------------------------------------
package sebam_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] address;
		logic [7:0]  wdata;
		logic        miso;
	} item_t;

	typedef struct packed {
		logic       cs_n;
		logic       sck;
		logic       mosi;
		logic       busy;
		logic       rvalid;
		logic [7:0] rdata;
	} result_t;

	localparam logic [7:0]  OP_WREN    = 8'h06;
	localparam logic [7:0]  OP_WRITE   = 8'h02;
	localparam logic [7:0]  OP_READ    = 8'h03;
	localparam logic [15:0] WAIT_RESET = 16'd1000;
	// address is padded to three bytes; upper bytes beyond the field read as zero
	localparam int          ADDR_PAD_W = 24;

endpackage
`default_nettype wire

// ===== rtl/sebam_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sebam_front: intake and classification
// Accepts input transactions, drops unknown commands and queues the rest.
// ----------------------------------------------------------------------------
module sebam_front import sebam_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic        miso,
	output logic             item_valid,
	output item_t            item,
	input  wire logic        item_pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = mem_q[rd_ptr_q];
	// command value three is consumed here and never reaches the engine
	assign wr_en      = push && !full && (cmd_t'(command) != CMD_NONE);
	assign rd_en      = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= '{cmd: cmd_t'(command), address: address,
				wdata: write_data, miso: miso};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sebam_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sebam_engine: SPI sequencer and result queue
// Runs the read and write frames one queued item per cycle while the result queue has room, buffers pin levels.
// ----------------------------------------------------------------------------
module sebam_engine import sebam_pkg::*; #(
	parameter int ADDR_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wait,
	input  wire logic        item_valid,
	input  wire item_t       item,
	output logic             item_pop,
	output logic             empty,
	output result_t          head,
	input  wire logic        pop
);

	localparam int         AddrBytes = (ADDR_WIDTH + 7) / 8;
	localparam logic [2:0] LastAddr  = 3'(AddrBytes);
	localparam logic [2:0] LastData  = 3'(AddrBytes + 1);

	typedef enum logic [2:0] {
		PH_IDLE, PH_WREN, PH_GAP, PH_SEND, PH_RECV, PH_HOLD
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [7:0]  shift_q, n_shift;
	logic [3:0]  bit_q, n_bit;
	logic [2:0]  byte_q, n_byte;
	logic [15:0] wait_q, n_wait;
	logic [15:0] addr_q, n_addr;
	logic [7:0]  data_q, n_data;
	logic        wr_q, n_wr;
	logic        clk_q, n_clk;
	logic [15:0] wwt_q;

	result_t     res;
	logic        res_we;
	logic        take;

	logic [7:0]           shifted;
	logic [3:0]           bit_inc;
	logic [2:0]           byte_inc;
	logic [15:0]          wait_dec;
	logic [1:0]           sel;
	logic [ADDR_PAD_W-1:0] addr_pad;
	logic [7:0]           next_byte;

	result_t mem_q [2];
	logic    wr_ptr_q;
	logic    rd_ptr_q;
	logic [1:0] ocnt_q;
	logic    rd_en;

	assign take     = item_valid && (ocnt_q != 2'd2);
	assign item_pop = take;
	assign empty    = (ocnt_q == 2'd0);
	assign head     = mem_q[rd_ptr_q];
	assign rd_en    = pop && !empty;

	assign shifted  = {shift_q[6:0], (phase_q == PH_RECV) ? item.miso : 1'b0};
	assign bit_inc  = bit_q + 4'd1;
	assign byte_inc = byte_q + 3'd1;
	assign wait_dec = wait_q - 16'd1;
	assign addr_pad = {{(ADDR_PAD_W - 16){1'b0}}, addr_q};
	// only looked at while byte_inc addresses an address byte, so at most 2
	assign sel      = 2'(LastAddr - byte_inc);

	always_comb begin
		if (byte_inc <= LastAddr) begin
			next_byte = addr_pad[{sel, 3'b000} +: 8];
		end else begin
			next_byte = data_q;
		end
	end

	always_comb begin
		n_phase = phase_q;
		n_shift = shift_q;
		n_bit   = bit_q;
		n_byte  = byte_q;
		n_wait  = wait_q;
		n_addr  = addr_q;
		n_data  = data_q;
		n_wr    = wr_q;
		n_clk   = clk_q;
		res     = '{cs_n: 1'b1, sck: 1'b0, mosi: 1'b0, busy: 1'b0,
			rvalid: 1'b0, rdata: 8'd0};
		res_we  = 1'b0;
		if (take) begin
			unique case (item.cmd)
				CMD_READ, CMD_WRITE: begin
					// requests while busy are dropped
					if (phase_q == PH_IDLE) begin
						n_addr  = item.address;
						n_data  = item.wdata;
						n_wr    = (item.cmd == CMD_WRITE);
						n_byte  = 3'd0;
						n_wait  = 16'd0;
						n_bit   = 4'd0;
						n_clk   = 1'b0;
						if (item.cmd == CMD_WRITE) begin
							n_phase = PH_WREN;
							n_shift = OP_WREN;
						end else begin
							n_phase = PH_SEND;
							n_shift = OP_READ;
						end
					end
				end
				CMD_TICK: begin
					res_we = 1'b1;
					unique case (phase_q)
						PH_WREN, PH_SEND, PH_RECV: begin
							res.busy = 1'b1;
							res.cs_n = 1'b0;
							res.mosi = (phase_q == PH_RECV) ? 1'b0 : shift_q[7];
							if (!clk_q) begin
								n_clk = 1'b1;
							end else begin
								res.sck = 1'b1;
								n_clk   = 1'b0;
								n_shift = shifted;
								n_bit   = bit_inc;
								if (bit_inc[3]) begin
									unique case (phase_q)
										PH_WREN: begin
											if (wwt_q == 16'd0) begin
												n_phase = PH_SEND;
												n_byte  = 3'd0;
												n_shift = OP_WRITE;
												n_bit   = 4'd0;
											end else begin
												n_wait  = wwt_q;
												n_phase = PH_GAP;
											end
										end
										PH_SEND: begin
											n_byte = byte_inc;
											if (wr_q && byte_inc > LastData) begin
												if (wwt_q == 16'd0) begin
													n_phase = PH_IDLE;
												end else begin
													n_wait  = wwt_q;
													n_phase = PH_HOLD;
												end
											end else if (!wr_q && byte_inc > LastAddr) begin
												n_phase = PH_RECV;
												n_shift = 8'd0;
												n_bit   = 4'd0;
											end else begin
												n_shift = next_byte;
												n_bit   = 4'd0;
											end
										end
										default: begin
											res.rvalid = 1'b1;
											res.rdata  = shifted;
											n_phase    = PH_IDLE;
										end
									endcase
								end
							end
						end
						PH_GAP: begin
							res.busy = 1'b1;
							n_wait   = wait_dec;
							if (wait_dec == 16'd0) begin
								n_phase = PH_SEND;
								n_byte  = 3'd0;
								n_shift = wr_q ? OP_WRITE : OP_READ;
								n_bit   = 4'd0;
								n_clk   = 1'b0;
							end
						end
						PH_HOLD: begin
							res.busy = 1'b1;
							res.cs_n = 1'b0;
							n_wait   = wait_dec;
							if (wait_dec == 16'd0) n_phase = PH_IDLE;
						end
						default: n_phase = PH_IDLE;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			shift_q <= 8'd0;
			bit_q   <= 4'd0;
			byte_q  <= 3'd0;
			wait_q  <= 16'd0;
			addr_q  <= 16'd0;
			data_q  <= 8'd0;
			wr_q    <= 1'b0;
			clk_q   <= 1'b0;
			wwt_q   <= WAIT_RESET;
		end else begin
			phase_q <= n_phase;
			shift_q <= n_shift;
			bit_q   <= n_bit;
			byte_q  <= n_byte;
			wait_q  <= n_wait;
			addr_q  <= n_addr;
			data_q  <= n_data;
			wr_q    <= n_wr;
			clk_q   <= n_clk;
			if (cfg_we) wwt_q <= cfg_wait;
		end
	end

	// result queue, two entries
	always_ff @(posedge clk) begin
		if (res_we) mem_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			ocnt_q   <= 2'd0;
		end else begin
			if (res_we) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({res_we, rd_en})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/spi_eeprom_byte_access_master.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spi_eeprom_byte_access_master: bit-banged SPI mode-0 master, 25xx EEPROM
// Byte read and write sequencer, one half SCK period per tick transaction.
// ----------------------------------------------------------------------------
// Usage notes:
// - Input side is a queue: a transaction is taken when push is high and full
//   is low. command 0 starts a read, 1 starts a write (WREN, gap, WRITE,
//   hold), 2 is a tick carrying the sampled miso level, 3 is discarded.
// - Requests make no result; they are ignored while a sequence runs.
// - Every tick makes exactly one result: pin levels chip_select_n,
//   serial_clock and mosi for that half period, busy_res, and read_valid
//   with read_data on the tick that samples the last read bit.
// - Result side is a queue: the oldest result sits on the ports while empty
//   is low and is taken when pop is high.
// - Throughput is one transaction per cycle while the result queue has
//   room; the sequencer handles one queued item per clock. A tick goes
//   through the intake queue, then the result queue, to the result ports.
// - If pop is held low the two-entry result queue fills, the sequencer
//   stops draining the two-entry intake queue, and full rises; nothing lost.
// - write_wait_ticks_we/write_wait_ticks load the wait length (reset 1000);
//   write it only while idle.
// - arst_n clears both queues and puts the sequencer in idle.
// - ADDR_WIDTH sets the address bytes sent: ceil(ADDR_WIDTH/8).
// ----------------------------------------------------------------------------
module spi_eeprom_byte_access_master import sebam_pkg::*; #(
	parameter int ADDR_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        write_wait_ticks_we,
	input  wire logic [15:0] write_wait_ticks,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic        miso,
	output logic             empty,
	input  wire logic        pop,
	output logic             chip_select_n,
	output logic             serial_clock,
	output logic             mosi,
	output logic             busy_res,
	output logic             read_valid,
	output logic [7:0]       read_data
);

	item_t   item;
	logic    item_valid;
	logic    item_pop;
	result_t head;

	sebam_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.address    (address),
		.write_data (write_data),
		.miso       (miso),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	sebam_engine #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (write_wait_ticks_we),
		.cfg_wait   (write_wait_ticks),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.empty      (empty),
		.head       (head),
		.pop        (pop)
	);

	// result transaction fields
	assign chip_select_n = head.cs_n;
	assign serial_clock  = head.sck;
	assign mosi          = head.mosi;
	assign busy_res      = head.busy;
	assign read_valid    = head.rvalid;
	assign read_data     = head.rdata;

endmodule
`default_nettype wire
